### sv/sbp_pkg.sv
// sphere box pushout package: field widths, queue entry and work item types
// no dependencies
`default_nettype none

package sbp_pkg;

    localparam int CW        = 32;
    localparam int RW        = 31;
    localparam int SKIN_W    = 16;
    localparam logic [SKIN_W-1:0] SKIN_RESET = 16'd66;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 33;
    localparam int QDEPTH    = 4;
    localparam int IN_W      = 384;
    localparam int OUT_W     = 64;

    typedef enum logic [1:0] {
        FACE_XN,
        FACE_XP,
        FACE_ZN,
        FACE_ZP
    } face_t;

    // request as handed from front to back
    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_z;
        logic [RW-1:0]        radius;
        logic                 neg_x;
        logic                 neg_z;
        logic [RW-1:0]        mag_x;
        logic [RW-1:0]        mag_z;
        face_t                face;
        logic                 axis_ok;
        logic [61:0]          sq_x;
        logic [61:0]          sq_y;
        logic [61:0]          sq_z;
        logic [61:0]          sq_r;
    } job_t;

    // request as carried through the back pipeline
    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_z;
        logic [RW-1:0]        radius;
        logic                 neg_x;
        logic                 neg_z;
        logic [RW-1:0]        mag_x;
        logic [RW-1:0]        mag_z;
        face_t                face;
        logic                 hit;
        logic                 outside;
    } work_t;

endpackage

`default_nettype wire

### sv/sbp_front.sv
// sphere box pushout front: box bounds, closest-point offset, face pick, squares
// depends on sbp_pkg
`default_nettype none

module sbp_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [sbp_pkg::IN_W-1:0] in_data,
    input  wire logic                    q_ready,
    output logic                         q_push,
    output sbp_pkg::job_t                q_data
);
    import sbp_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_z;
        logic [RW-1:0]        radius;
        logic                 neg_x;
        logic                 neg_z;
        logic [RW-1:0]        mag_x;
        logic [RW-1:0]        mag_y;
        logic [RW-1:0]        mag_z;
        face_t                face;
        logic                 axis_ok;
    } cls_t;

    logic        [CW-1:0] c_in  [3];
    logic        [CW-1:0] b_in  [3];
    logic        [RW-1:0] h_in  [3];
    logic signed [33:0]   c_e   [3];
    logic signed [33:0]   lo    [3];
    logic signed [33:0]   hi    [3];
    logic signed [33:0]   mag_e [3];
    logic                 below [3];
    logic                 ok    [3];
    logic [RW-1:0]        r_in;
    logic signed [33:0]   best;
    logic signed [33:0]   dist_xp;
    logic signed [33:0]   dist_zn;
    logic signed [33:0]   dist_zp;
    face_t                face;
    cls_t                 cls_next;
    cls_t                 cls_reg;
    logic                 cls_valid_reg;
    job_t                 job_reg;
    logic                 job_valid_reg;
    logic                 adv;

    assign c_in[0] = in_data[31:0];
    assign c_in[1] = in_data[63:32];
    assign c_in[2] = in_data[95:64];
    assign r_in    = in_data[126:96];
    assign b_in[0] = in_data[158:127];
    assign b_in[1] = in_data[190:159];
    assign b_in[2] = in_data[222:191];
    assign h_in[0] = in_data[253:223];
    assign h_in[1] = in_data[284:254];
    assign h_in[2] = in_data[315:285];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_e[i]   = {{2{c_in[i][CW-1]}}, c_in[i]};
            lo[i]    = {{2{b_in[i][CW-1]}}, b_in[i]} - {3'b000, h_in[i]};
            hi[i]    = {{2{b_in[i][CW-1]}}, b_in[i]} + {3'b000, h_in[i]};
            below[i] = c_e[i] < lo[i];
            if (below[i])
                mag_e[i] = lo[i] - c_e[i];
            else if (c_e[i] > hi[i])
                mag_e[i] = c_e[i] - hi[i];
            else
                mag_e[i] = '0;
            ok[i] = mag_e[i] <= $signed({3'b000, r_in});
        end
        // nearest face, earlier face wins a tie
        dist_xp = hi[0] - c_e[0];
        dist_zn = c_e[2] - lo[2];
        dist_zp = hi[2] - c_e[2];
        best    = c_e[0] - lo[0];
        face    = FACE_XN;
        if (dist_xp < best)
        begin
            best = dist_xp;
            face = FACE_XP;
        end
        if (dist_zn < best)
        begin
            best = dist_zn;
            face = FACE_ZN;
        end
        if (dist_zp < best)
            face = FACE_ZP;

        cls_next.pos_x   = in_data[347:316];
        cls_next.pos_z   = in_data[379:348];
        cls_next.radius  = r_in;
        cls_next.neg_x   = below[0];
        cls_next.neg_z   = below[2];
        cls_next.mag_x   = mag_e[0][RW-1:0];
        cls_next.mag_y   = mag_e[1][RW-1:0];
        cls_next.mag_z   = mag_e[2][RW-1:0];
        cls_next.face    = face;
        cls_next.axis_ok = ok[0] && ok[1] && ok[2];
    end

    assign adv      = !job_valid_reg || q_ready;
    assign in_ready = adv;
    assign q_push   = job_valid_reg && q_ready;
    assign q_data   = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cls_valid_reg <= in_valid;
            job_valid_reg <= cls_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg         <= cls_next;
            job_reg.pos_x   <= cls_reg.pos_x;
            job_reg.pos_z   <= cls_reg.pos_z;
            job_reg.radius  <= cls_reg.radius;
            job_reg.neg_x   <= cls_reg.neg_x;
            job_reg.neg_z   <= cls_reg.neg_z;
            job_reg.mag_x   <= cls_reg.mag_x;
            job_reg.mag_z   <= cls_reg.mag_z;
            job_reg.face    <= cls_reg.face;
            job_reg.axis_ok <= cls_reg.axis_ok;
            job_reg.sq_x    <= cls_reg.mag_x * cls_reg.mag_x;
            job_reg.sq_y    <= cls_reg.mag_y * cls_reg.mag_y;
            job_reg.sq_z    <= cls_reg.mag_z * cls_reg.mag_z;
            job_reg.sq_r    <= cls_reg.radius * cls_reg.radius;
        end
    end

endmodule

`default_nettype wire

### sv/sbp_queue.sv
// sphere box pushout queue between front and back
// depends on sbp_pkg
`default_nettype none

module sbp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  sbp_pkg::job_t      push_data,
    output logic               ready,
    input  wire logic          pop,
    output logic               valid,
    output sbp_pkg::job_t      pop_data
);
    import sbp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    job_t            mem_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    assign valid    = count_reg != '0;
    assign ready    = (count_reg != (PW+1)'(QDEPTH)) || pop;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

### sv/sbp_back.sv
// sphere box pushout back: overlap test, root pipeline, push scaling, saturation
// depends on sbp_pkg
`default_nettype none

module sbp_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [sbp_pkg::SKIN_W-1:0] skin,
    input  wire logic                       q_valid,
    input  sbp_pkg::job_t                   q_data,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [sbp_pkg::OUT_W-1:0]       out_data,
    output logic                            out_flag
);
    import sbp_pkg::*;

    logic               adv;
    logic [63:0]        d2;
    work_t              w0;
    logic [61:0]        n0;

    logic               sq_v_reg   [SQ_STEPS+1];
    work_t              sq_w_reg   [SQ_STEPS+1];
    logic [61:0]        sq_n_reg   [SQ_STEPS+1];
    logic [61:0]        sq_res_reg [SQ_STEPS+1];

    logic [RW-1:0]      root_len;
    logic [RW-1:0]      root_adj;
    logic [32:0]        pen_wide;
    logic [31:0]        pen;
    logic [63:0]        num_x;
    logic [63:0]        num_z;

    logic               dv_v_reg    [DIV_STEPS+1];
    work_t              dv_w_reg    [DIV_STEPS+1];
    logic [RW-1:0]      dv_dist_reg [DIV_STEPS+1];
    logic [63:0]        dv_nx_reg   [DIV_STEPS+1];
    logic [63:0]        dv_nz_reg   [DIV_STEPS+1];
    logic [RW-1:0]      dv_rx_reg   [DIV_STEPS+1];
    logic [RW-1:0]      dv_rz_reg   [DIV_STEPS+1];
    logic [32:0]        dv_qx_reg   [DIV_STEPS+1];
    logic [32:0]        dv_qz_reg   [DIV_STEPS+1];

    work_t              wf;
    logic [31:0]        amt;
    logic signed [33:0] push_x;
    logic signed [33:0] push_z;
    logic signed [34:0] sum_x;
    logic signed [34:0] sum_z;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_flag_reg;
    logic [OUT_W-1:0]   out_data_next;
    logic               out_flag_next;

    function automatic logic [CW-1:0] sat32(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            return 32'h8000_0000;
        else
            return v[CW-1:0];
    endfunction

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    // overlap test and entry into the root pipeline
    always_comb
    begin
        d2 = 64'(q_data.sq_x) + 64'(q_data.sq_y) + 64'(q_data.sq_z);
        w0.pos_x   = q_data.pos_x;
        w0.pos_z   = q_data.pos_z;
        w0.radius  = q_data.radius;
        w0.neg_x   = q_data.neg_x;
        w0.neg_z   = q_data.neg_z;
        w0.mag_x   = q_data.mag_x;
        w0.mag_z   = q_data.mag_z;
        w0.face    = q_data.face;
        w0.hit     = q_data.axis_ok && (d2 <= 64'(q_data.sq_r));
        w0.outside = d2 != '0;
        n0 = (w0.hit && w0.outside) ? d2[61:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (adv)
            sq_v_reg[0] <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_w_reg[0]   <= w0;
            sq_n_reg[0]   <= n0;
            sq_res_reg[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [61:0] trial;

        assign trial = sq_res_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (adv)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_w_reg[k+1] <= sq_w_reg[k];
                if (sq_n_reg[k] >= trial)
                begin
                    sq_n_reg[k+1]   <= sq_n_reg[k] - trial;
                    sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + BIT;
                end
                else
                begin
                    sq_n_reg[k+1]   <= sq_n_reg[k];
                    sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
                end
            end
        end
    end

    // penetration depth and scaled numerators
    always_comb
    begin
        root_len = sq_res_reg[SQ_STEPS][RW-1:0];
        root_adj = (root_len == '0) ? RW'(1) : root_len;
        pen_wide = {2'b00, sq_w_reg[SQ_STEPS].radius} - {2'b00, root_len}
                 + {17'b0, skin};
        pen      = pen_wide[31:0];
        num_x    = ({33'b0, sq_w_reg[SQ_STEPS].mag_x} * {32'b0, pen})
                 + {33'b0, 1'b0, root_adj[RW-1:1]};
        num_z    = ({33'b0, sq_w_reg[SQ_STEPS].mag_z} * {32'b0, pen})
                 + {33'b0, 1'b0, root_adj[RW-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_w_reg[0]    <= sq_w_reg[SQ_STEPS];
            dv_dist_reg[0] <= root_adj;
            dv_nx_reg[0]   <= num_x;
            dv_nz_reg[0]   <= num_z;
            dv_rx_reg[0]   <= num_x[63:DIV_STEPS];
            dv_rz_reg[0]   <= num_z[63:DIV_STEPS];
            dv_qx_reg[0]   <= '0;
            dv_qz_reg[0]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage, x and z side by side
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [RW:0] tx;
        logic [RW:0] tz;
        logic [RW:0] dd;
        logic        gx;
        logic        gz;
        logic [RW:0] sx;
        logic [RW:0] sz;

        assign dd = {1'b0, dv_dist_reg[k]};
        assign tx = {dv_rx_reg[k], dv_nx_reg[k][DIV_STEPS-1-k]};
        assign tz = {dv_rz_reg[k], dv_nz_reg[k][DIV_STEPS-1-k]};
        assign gx = tx >= dd;
        assign gz = tz >= dd;
        assign sx = tx - dd;
        assign sz = tz - dd;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (adv)
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_w_reg[k+1]    <= dv_w_reg[k];
                dv_dist_reg[k+1] <= dv_dist_reg[k];
                dv_nx_reg[k+1]   <= dv_nx_reg[k];
                dv_nz_reg[k+1]   <= dv_nz_reg[k];
                dv_rx_reg[k+1]   <= gx ? sx[RW-1:0] : tx[RW-1:0];
                dv_rz_reg[k+1]   <= gz ? sz[RW-1:0] : tz[RW-1:0];
                dv_qx_reg[k+1]   <= {dv_qx_reg[k][31:0], gx};
                dv_qz_reg[k+1]   <= {dv_qz_reg[k][31:0], gz};
            end
        end
    end

    // push selection and saturating add
    always_comb
    begin
        wf     = dv_w_reg[DIV_STEPS];
        amt    = {1'b0, wf.radius} + {16'b0, skin};
        push_x = '0;
        push_z = '0;
        if (wf.hit && wf.outside)
        begin
            push_x = wf.neg_x ? -$signed({1'b0, dv_qx_reg[DIV_STEPS]})
                              :  $signed({1'b0, dv_qx_reg[DIV_STEPS]});
            push_z = wf.neg_z ? -$signed({1'b0, dv_qz_reg[DIV_STEPS]})
                              :  $signed({1'b0, dv_qz_reg[DIV_STEPS]});
        end
        else if (wf.hit)
        begin
            unique case (wf.face)
                FACE_XN: push_x = -$signed({2'b00, amt});
                FACE_XP: push_x =  $signed({2'b00, amt});
                FACE_ZN: push_z = -$signed({2'b00, amt});
                FACE_ZP: push_z =  $signed({2'b00, amt});
                default: push_x = '0;
            endcase
        end
        sum_x = {{3{wf.pos_x[CW-1]}}, wf.pos_x} + {push_x[33], push_x};
        sum_z = {{3{wf.pos_z[CW-1]}}, wf.pos_z} + {push_z[33], push_z};
        out_data_next = {sat32(sum_z), sat32(sum_x)};
        out_flag_next = wf.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_v_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_flag_reg <= out_flag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_flag  = out_flag_reg;

endmodule

`default_nettype wire

### sv/sphere_box_pushout_unit.sv
// path: front cls and job registers, queue, root pipe, divide pipe, output register
// throughput: one request per cycle unless output stalls; root pipe 31 stages, divide 33
// a stalled output holds the back pipe; the four-entry queue takes front work until full
// reset: asynchronous active low, clears all valid bits and the queue, skin margin to 66
// top level: front, queue and back; depends on sbp_pkg
`default_nettype none

module sphere_box_pushout_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,   // skin_margin
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, box_x, box_y, box_z,
    // half_x, half_y, half_z, pos_x, pos_z, zero fill
    input  wire logic [383:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,       // new_pos_x, new_pos_z
    output logic [0:0]        m_tuser        // contact
);
    import sbp_pkg::*;

    logic [SKIN_W-1:0] skin_reg;
    logic              q_ready;
    logic              q_push;
    job_t              q_in;
    logic              q_valid;
    logic              q_pop;
    job_t              q_out;
    logic              flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skin_reg <= SKIN_RESET;
        else if (cfg_wr_en)
            skin_reg <= cfg_wr_data;
    end

    sbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    sbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    sbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .skin      (skin_reg),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_flag  (flag)
    );

    assign m_tuser = flag;

endmodule

`default_nettype wire

### sv/sbp_chk.sv
// sphere box pushout port checker and its bind to the top level
// depends on sphere_box_pushout_unit ports only
`default_nettype none

module sbp_chk (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side only backs up behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

    // pipe still empty in the cycle after reset is released
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !m_tvalid)
        else $error("result valid too soon after reset");

endmodule

bind sphere_box_pushout_unit sbp_chk u_sbp_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
